### rtl/core/scvs_pkg.sv
package scvs_pkg;

   localparam int AXIS_W     = 16;
   localparam int SCALE_W    = 15;
   localparam int DECEL_W    = 16;
   localparam int TIME_W     = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PROD_W     = 32;

   localparam int DEFAULT_DT_MS_DEF   = 5;
   localparam int MAX_DT_MS_DEF       = 50;
   localparam int LIN_SETTLE_EPS_DEF  = 20;
   localparam int TURN_SETTLE_EPS_DEF = 50;

   localparam logic [SCALE_W-1:0] DEADZONE_RST    = 15'd1966;
   localparam logic [SCALE_W-1:0] LIN_LOW_RST     = 15'd500;
   localparam logic [SCALE_W-1:0] LIN_HIGH_RST    = 15'd1500;
   localparam logic [SCALE_W-1:0] TURN_LOW_RST    = 15'd7500;
   localparam logic [SCALE_W-1:0] TURN_HIGH_RST   = 15'd15000;
   localparam logic [DECEL_W-1:0] BRAKE_LIN_RST   = 16'd5000;
   localparam logic [DECEL_W-1:0] BRAKE_TURN_RST  = 16'd50000;

   // braking step = (decel * dt + 500) / 1000, divide as (n >> 3) / 125
   localparam int STEP_NUM_W  = 26;
   localparam int STEP_W      = 16;
   localparam int DIV_PRE     = 3;
   localparam int RECIP_W     = 24;
   localparam int RECIP_SHIFT = 30;
   localparam logic [RECIP_W-1:0]    RECIP_125  = 24'd8589935;
   localparam logic [STEP_NUM_W-1:0] STEP_ROUND = 26'd500;

   localparam logic [PROD_W-2:0] Q15_HALF = 31'd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEADZONE   = 3'd0,
      CSR_LIN_LOW    = 3'd1,
      CSR_LIN_HIGH   = 3'd2,
      CSR_TURN_LOW   = 3'd3,
      CSR_TURN_HIGH  = 3'd4,
      CSR_BRAKE_LIN  = 3'd5,
      CSR_BRAKE_TURN = 3'd6
   } csr_idx_type;

   typedef struct packed {
      logic                     pv;
      logic                     gear;
      logic                     idle;
      logic signed [PROD_W-1:0] px;
      logic signed [PROD_W-1:0] py;
      logic signed [PROD_W-1:0] pt;
      logic [STEP_NUM_W-1:0]    lprod;
      logic [STEP_NUM_W-1:0]    tprod;
   } mul_stage_type;

   typedef struct packed {
      logic                     pv;
      logic                     gear;
      logic                     idle;
      logic signed [AXIS_W-1:0] sx;
      logic signed [AXIS_W-1:0] sy;
      logic signed [AXIS_W-1:0] st;
      logic [STEP_W-1:0]        lstep;
      logic [STEP_W-1:0]        tstep;
   } cmd_stage_type;

   // product / 32768, nearest, ties away from zero, saturated
   function automatic logic signed [AXIS_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-2:0] mag;
      logic [PROD_W-2:0] sum;
      logic [AXIS_W-1:0] q;
      mag = p[PROD_W-1] ? (PROD_W-1)'(-p) : p[PROD_W-2:0];
      sum = mag + Q15_HALF;
      q   = sum[AXIS_W+14:15];
      if (p[PROD_W-1]) begin
         round_q15 = -$signed(q);
      end else if (q[AXIS_W-1]) begin
         round_q15 = {1'b0, {(AXIS_W-1){1'b1}}};
      end else begin
         round_q15 = $signed(q);
      end
   endfunction

   function automatic logic [STEP_W-1:0] step_div(input logic [STEP_NUM_W-1:0] prod);
      logic [STEP_NUM_W-1:0]           n;
      logic [STEP_NUM_W-DIV_PRE-1:0]   h;
      logic [STEP_NUM_W-DIV_PRE+RECIP_W-1:0] full;
      n    = prod + STEP_ROUND;
      h    = n[STEP_NUM_W-1:DIV_PRE];
      full = h * RECIP_125;
      step_div = full[RECIP_SHIFT+STEP_W-1:RECIP_SHIFT];
   endfunction

   function automatic logic signed [AXIS_W-1:0] brake(input logic signed [AXIS_W-1:0] c,
                                                      input logic [STEP_W-1:0] s);
      logic signed [AXIS_W+1:0] c_w;
      logic signed [AXIS_W+1:0] s_w;
      logic signed [AXIS_W+1:0] r;
      c_w = (AXIS_W+2)'(c);
      s_w = $signed({2'b00, s});
      if (c_w > s_w) begin
         r = c_w - s_w;
      end else if (c_w < -s_w) begin
         r = c_w + s_w;
      end else begin
         r = '0;
      end
      brake = r[AXIS_W-1:0];
   endfunction

   function automatic logic [AXIS_W:0] abs_cmd(input logic signed [AXIS_W-1:0] c);
      logic signed [AXIS_W:0] c_w;
      c_w = (AXIS_W+1)'(c);
      abs_cmd = c_w[AXIS_W] ? unsigned'(-c_w) : unsigned'(c_w);
   endfunction

endpackage

### rtl/core/stick_to_chassis_velocity_shaper.sv
// Gamepad sample to chassis velocity command shaper. One word in, one word out,
// in order. A new sample can be taken every cycle while req_stall is low; the
// result word passes through the four register stages: input capture,
// multipliers (deadzone squares, stick scaling, decel * elapsed time),
// rounding plus the divide by 1000 for the braking step, and the command
// update that brakes or loads the held speeds. Gear, button history and the
// last time stamp are tracked in the multiplier stage; the held commands in
// the last stage, so back-to-back samples see each other's effect exactly.
// Configuration writes are always ready and are to be made with the block
// idle. csr_index values above 6 are ignored.
module stick_to_chassis_velocity_shaper #(
   parameter int unsigned DEFAULT_DT_MS   = scvs_pkg::DEFAULT_DT_MS_DEF,
   parameter int unsigned MAX_DT_MS       = scvs_pkg::MAX_DT_MS_DEF,
   parameter int unsigned LIN_SETTLE_EPS  = scvs_pkg::LIN_SETTLE_EPS_DEF,
   parameter int unsigned TURN_SETTLE_EPS = scvs_pkg::TURN_SETTLE_EPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_packet_valid,
   input  logic signed [scvs_pkg::AXIS_W-1:0]    req_stick_x,
   input  logic signed [scvs_pkg::AXIS_W-1:0]    req_stick_y,
   input  logic signed [scvs_pkg::AXIS_W-1:0]    req_stick_turn,
   input  logic                                  req_gear_button,
   input  logic [scvs_pkg::TIME_W-1:0]           req_now_ms,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_is_static,
   output logic signed [scvs_pkg::AXIS_W-1:0]    rsp_speed_x,
   output logic signed [scvs_pkg::AXIS_W-1:0]    rsp_speed_y,
   output logic signed [scvs_pkg::AXIS_W-1:0]    rsp_turn_rate,
   output logic                                  rsp_low_gear_now,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [scvs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [scvs_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import scvs_pkg::*;

   localparam int unsigned DT_TOP = (MAX_DT_MS > DEFAULT_DT_MS) ? MAX_DT_MS : DEFAULT_DT_MS;
   localparam int DT_W = $clog2(DT_TOP + 1);

   // configuration
   logic [SCALE_W-1:0] deadzone_ff, lin_low_ff, lin_high_ff, turn_low_ff, turn_high_ff;
   logic [DECEL_W-1:0] brake_lin_ff, brake_turn_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff   <= DEADZONE_RST;
         lin_low_ff    <= LIN_LOW_RST;
         lin_high_ff   <= LIN_HIGH_RST;
         turn_low_ff   <= TURN_LOW_RST;
         turn_high_ff  <= TURN_HIGH_RST;
         brake_lin_ff  <= BRAKE_LIN_RST;
         brake_turn_ff <= BRAKE_TURN_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_DEADZONE:   deadzone_ff   <= csr_wdata[SCALE_W-1:0];
            CSR_LIN_LOW:    lin_low_ff    <= csr_wdata[SCALE_W-1:0];
            CSR_LIN_HIGH:   lin_high_ff   <= csr_wdata[SCALE_W-1:0];
            CSR_TURN_LOW:   turn_low_ff   <= csr_wdata[SCALE_W-1:0];
            CSR_TURN_HIGH:  turn_high_ff  <= csr_wdata[SCALE_W-1:0];
            CSR_BRAKE_LIN:  brake_lin_ff  <= csr_wdata[DECEL_W-1:0];
            CSR_BRAKE_TURN: brake_turn_ff <= csr_wdata[DECEL_W-1:0];
            default: ;
         endcase
      end
   end

   // flow control
   logic s1_v_ff, s2_v_ff, s3_v_ff, rsp_valid_ff;
   logic out_en, s3_en, s2_en, s1_en;

   assign out_en    = !rsp_valid_ff || !rsp_stall;
   assign s3_en     = !s3_v_ff || out_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_stall = !s1_en;

   // stage 1: input capture
   logic                     s1_pv_ff, s1_btn_ff;
   logic signed [AXIS_W-1:0] s1_x_ff, s1_y_ff, s1_t_ff;
   logic [TIME_W-1:0]        s1_now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_pv_ff  <= req_packet_valid;
         s1_x_ff   <= req_stick_x;
         s1_y_ff   <= req_stick_y;
         s1_t_ff   <= req_stick_turn;
         s1_btn_ff <= req_gear_button;
         s1_now_ff <= req_now_ms;
      end
   end

   // stage 2: gear, elapsed time, multipliers
   logic              gear_lo_ff, gear_lo_in, btn_prev_ff;
   logic [TIME_W-1:0] last_time_ff, diff;
   logic [DT_W-1:0]   dt;
   logic              s1_take;

   assign s1_take = s1_v_ff && s2_en;
   assign diff    = s1_now_ff - last_time_ff;

   always_comb begin
      if (last_time_ff == '0 || diff == '0 || diff[TIME_W-1]) begin
         dt = DT_W'(DEFAULT_DT_MS);
      end else if (diff > TIME_W'(MAX_DT_MS)) begin
         dt = DT_W'(MAX_DT_MS);
      end else begin
         dt = diff[DT_W-1:0];
      end
   end

   assign gear_lo_in = (s1_btn_ff && !btn_prev_ff) ? !gear_lo_ff : gear_lo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gear_lo_ff   <= 1'b1;
         btn_prev_ff  <= 1'b0;
         last_time_ff <= '0;
      end else if (s1_take) begin
         last_time_ff <= s1_now_ff;
         if (s1_pv_ff) begin
            gear_lo_ff  <= gear_lo_in;
            btn_prev_ff <= s1_btn_ff;
         end
      end
   end

   logic [SCALE_W-1:0]       lin_sel, turn_sel;
   logic signed [PROD_W-1:0] sq_x, sq_y;
   logic [PROD_W-1:0]        mag2;
   logic [2*SCALE_W-1:0]     dz2;
   logic signed [AXIS_W:0]   x_neg, t_neg, t_w;
   logic [AXIS_W:0]          t_abs;
   logic                     zero_xy, zero_t, idle_xy, idle_t;
   logic signed [PROD_W-1:0] px_w, py_w, pt_w;
   logic [DECEL_W+DT_W-1:0]  lprod_w, tprod_w;
   mul_stage_type            s2_in, s2_ff;

   assign lin_sel  = gear_lo_in ? lin_low_ff : lin_high_ff;
   assign turn_sel = gear_lo_in ? turn_low_ff : turn_high_ff;
   assign sq_x     = s1_x_ff * s1_x_ff;
   assign sq_y     = s1_y_ff * s1_y_ff;
   assign mag2     = unsigned'(sq_x) + unsigned'(sq_y);
   assign dz2      = deadzone_ff * deadzone_ff;
   assign x_neg    = -((AXIS_W+1)'(s1_x_ff));
   assign t_w      = (AXIS_W+1)'(s1_t_ff);
   assign t_neg    = -t_w;
   assign t_abs    = s1_t_ff[AXIS_W-1] ? unsigned'(t_neg) : unsigned'(t_w);
   assign zero_xy  = mag2 < PROD_W'(dz2);
   assign zero_t   = t_abs < (AXIS_W+1)'(deadzone_ff);
   assign idle_xy  = zero_xy || (s1_x_ff == '0 && s1_y_ff == '0);
   assign idle_t   = zero_t || s1_t_ff == '0;
   assign px_w     = x_neg * $signed({1'b0, lin_sel});
   assign py_w     = s1_y_ff * $signed({1'b0, lin_sel});
   assign pt_w     = t_neg * $signed({1'b0, turn_sel});
   assign lprod_w  = brake_lin_ff * dt;
   assign tprod_w  = brake_turn_ff * dt;

   always_comb begin
      s2_in.pv    = s1_pv_ff;
      s2_in.gear  = s1_pv_ff ? gear_lo_in : gear_lo_ff;
      s2_in.idle  = idle_xy && idle_t;
      s2_in.px    = zero_xy ? '0 : px_w;
      s2_in.py    = zero_xy ? '0 : py_w;
      s2_in.pt    = zero_t ? '0 : pt_w;
      s2_in.lprod = STEP_NUM_W'(lprod_w);
      s2_in.tprod = STEP_NUM_W'(tprod_w);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: rounding and braking step
   cmd_stage_type s3_in, s3_ff;

   always_comb begin
      s3_in.pv    = s2_ff.pv;
      s3_in.gear  = s2_ff.gear;
      s3_in.idle  = s2_ff.idle;
      s3_in.sx    = round_q15(s2_ff.px);
      s3_in.sy    = round_q15(s2_ff.py);
      s3_in.st    = round_q15(s2_ff.pt);
      s3_in.lstep = step_div(s2_ff.lprod);
      s3_in.tstep = step_div(s2_ff.tprod);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (s3_en) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_ff <= s3_in;
      end
   end

   // stage 4: held commands and result word
   logic signed [AXIS_W-1:0] cmd_x_ff, cmd_y_ff, cmd_t_ff;
   logic signed [AXIS_W-1:0] cmd_x_in, cmd_y_in, cmd_t_in;
   logic signed [AXIS_W-1:0] brk_x, brk_y, brk_t;
   logic                     settled, static_in, s3_take;
   logic                     rsp_static_ff, rsp_gear_ff;
   logic signed [AXIS_W-1:0] rsp_x_ff, rsp_y_ff, rsp_t_ff;

   assign s3_take = s3_v_ff && out_en;
   assign brk_x   = brake(cmd_x_ff, s3_ff.lstep);
   assign brk_y   = brake(cmd_y_ff, s3_ff.lstep);
   assign brk_t   = brake(cmd_t_ff, s3_ff.tstep);
   assign settled = abs_cmd(brk_x) < (AXIS_W+1)'(LIN_SETTLE_EPS)
                 && abs_cmd(brk_y) < (AXIS_W+1)'(LIN_SETTLE_EPS)
                 && abs_cmd(brk_t) < (AXIS_W+1)'(TURN_SETTLE_EPS);

   always_comb begin
      if (!s3_ff.pv || (s3_ff.idle && settled)) begin
         cmd_x_in  = '0;
         cmd_y_in  = '0;
         cmd_t_in  = '0;
         static_in = 1'b1;
      end else if (s3_ff.idle) begin
         cmd_x_in  = brk_x;
         cmd_y_in  = brk_y;
         cmd_t_in  = brk_t;
         static_in = 1'b0;
      end else begin
         cmd_x_in  = s3_ff.sx;
         cmd_y_in  = s3_ff.sy;
         cmd_t_in  = s3_ff.st;
         static_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_x_ff     <= '0;
         cmd_y_ff     <= '0;
         cmd_t_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (out_en) begin
            rsp_valid_ff <= s3_v_ff;
         end
         if (s3_take) begin
            cmd_x_ff <= cmd_x_in;
            cmd_y_ff <= cmd_y_in;
            cmd_t_ff <= cmd_t_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_take) begin
         rsp_static_ff <= static_in;
         rsp_x_ff      <= cmd_x_in;
         rsp_y_ff      <= cmd_y_in;
         rsp_t_ff      <= cmd_t_in;
         rsp_gear_ff   <= s3_ff.gear;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_is_static    = rsp_static_ff;
   assign rsp_speed_x      = rsp_x_ff;
   assign rsp_speed_y      = rsp_y_ff;
   assign rsp_turn_rate    = rsp_t_ff;
   assign rsp_low_gear_now = rsp_gear_ff;

   // checks
   a_static_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_static_ff |-> rsp_x_ff == '0 && rsp_y_ff == '0 && rsp_t_ff == '0)
      else $error("static word with nonzero speed");

   a_missing_static: assert property (@(posedge clock) disable iff (reset)
      s3_take && !s3_ff.pv |=> rsp_valid_ff && rsp_static_ff && cmd_x_ff == '0)
      else $error("missing packet did not clear commands");

   a_gear_hold: assert property (@(posedge clock) disable iff (reset)
      s1_take && !s1_pv_ff |=> gear_lo_ff == $past(gear_lo_ff)
                               && btn_prev_ff == $past(btn_prev_ff))
      else $error("gear changed on missing packet");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_v_ff && s2_v_ff && s3_v_ff && rsp_valid_ff && rsp_stall |-> req_stall)
      else $error("word taken into full pipeline");

   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_v_ff)
      else $error("accepted word lost at input");

endmodule
